### hw/rtl/rss_pkg.sv
package rss_pkg;

  localparam int DefaultDepth = 64;
  localparam int CapW         = 7;
  localparam logic [CapW-1:0] CapReset = 7'd64;
  localparam int PaddrW       = 3;
  localparam int PdataW       = 32;
  localparam logic RegCapIdx  = 1'b0;

  typedef struct packed {
    logic signed [31:0] id;
    logic signed [31:0] quantity;
    logic [63:0]        label;
  } rec_t;

  typedef enum logic [2:0] {
    StIdle,
    StCmp,
    StPlace,
    StEmitRd,
    StEmitLd
  } state_e;

endpackage

### hw/rtl/rss_if.sv
interface rss_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rec_id;
  logic signed [31:0] rec_quantity;
  logic [63:0]        rec_label;
  logic               load_last;

  modport source (output valid, rec_id, rec_quantity, rec_label, load_last, input ready);
  modport sink   (input valid, rec_id, rec_quantity, rec_label, load_last, output ready);
endinterface

interface rss_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_id;
  logic signed [31:0] out_quantity;
  logic [63:0]        out_label;
  logic               out_last;
  logic               out_overflowed;

  modport source (output valid, out_id, out_quantity, out_label, out_last, out_overflowed,
                  input ready);
  modport sink   (input valid, out_id, out_quantity, out_label, out_last, out_overflowed,
                  output ready);
endinterface

### hw/rtl/record_stack_sort_by_key.sv
// channel | dir | payload                                             | handshake
// in_i    | in  | rec_id, rec_quantity, rec_label, load_last          | valid/ready
// out_o   | out | out_id, out_quantity, out_label, out_last,          | valid/ready
//         |     | out_overflowed                                      |
// apb     | in  | stack_capacity at byte address 0                    | psel/penable
//
// a dropped push or one into an empty store is settled as it is taken; any other push
// shifts each held record it moves past one slot toward the tail, one shift per cycle
// through the single memory port pair, and is then written in its place
// each emitted record is read from memory, then loaded into the output register, the
// load waiting while out_o stalls; in_i is not ready during insertion or emission
// reset clears the state, count and overflow flag; the store needs no clearing
module record_stack_sort_by_key #(
  parameter int DEPTH = rss_pkg::DefaultDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rss_in_if.sink                      in_i,
  rss_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rss_pkg::PaddrW-1:0]  paddr,
  input  logic [rss_pkg::PdataW-1:0]  pwdata,
  output logic [rss_pkg::PdataW-1:0]  prdata,
  output logic                        pready
);

  localparam int AddrW = $clog2(DEPTH);
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int MW    = (CntW > rss_pkg::CapW) ? CntW : rss_pkg::CapW;

  rss_pkg::state_e state_q, state_d;
  logic [rss_pkg::CapW-1:0] cap_q;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic             ovf_q, ovf_d;
  logic             last_q, last_d;
  rss_pkg::rec_t    new_q, new_d;
  logic             oval_q, oval_d;
  logic             oload;
  rss_pkg::rec_t    orec_q;
  logic             olast_q, oovf_q;
  logic             olast_d;

  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  rss_pkg::rec_t    mem_wdata, mem_rdata;
  rss_pkg::rec_t    in_rec;
  logic             key_le;
  logic [MW-1:0]    effcap;
  logic [CntW-1:0]  idx_m1, idx_m2, idx_p1, fill_p1;
  logic             cfg_wr;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == rss_pkg::RegCapIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= rss_pkg::CapReset;
    end else if (cfg_wr) begin
      cap_q <= pwdata[rss_pkg::CapW-1:0];
    end
  end

  assign prdata = (paddr[2] == rss_pkg::RegCapIdx) ?
                  {{(rss_pkg::PdataW-rss_pkg::CapW){1'b0}}, cap_q} : '0;

  always_comb begin
    if (cap_q == '0) begin
      effcap = MW'(1);
    end else if (MW'(cap_q) > MW'(DEPTH)) begin
      effcap = MW'(DEPTH);
    end else begin
      effcap = MW'(cap_q);
    end
  end

  assign in_rec.id       = in_i.rec_id;
  assign in_rec.quantity = in_i.rec_quantity;
  assign in_rec.label    = in_i.rec_label;

  rss_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rss_keycmp u_keycmp (
    .a_i  (mem_rdata.quantity),
    .b_i  (new_q.quantity),
    .le_o (key_le)
  );

  assign idx_m1  = CntW'(idx_q - 1'b1);
  assign idx_m2  = CntW'(idx_q - 2'd2);
  assign idx_p1  = CntW'(idx_q + 1'b1);
  assign fill_p1 = CntW'(fill_q + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rss_pkg::StIdle;
      fill_q  <= '0;
      idx_q   <= '0;
      ovf_q   <= 1'b0;
      last_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      ovf_q   <= ovf_d;
      last_q  <= last_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
    if (oload) begin
      orec_q  <= mem_rdata;
      olast_q <= olast_d;
      oovf_q  <= ovf_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    idx_d      = idx_q;
    ovf_d      = ovf_q;
    last_d     = last_q;
    new_d      = new_q;
    mem_we     = 1'b0;
    mem_waddr  = idx_q[AddrW-1:0];
    mem_wdata  = new_q;
    mem_re     = 1'b0;
    mem_raddr  = idx_m1[AddrW-1:0];
    oload      = 1'b0;
    olast_d    = (idx_p1 == fill_q);
    oval_d     = oval_q && !out_o.ready;
    in_i.ready = 1'b0;

    case (state_q)
      rss_pkg::StIdle: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          new_d  = in_rec;
          last_d = in_i.load_last;
          if (MW'(fill_q) >= effcap) begin
            ovf_d = 1'b1;
            if (in_i.load_last) begin
              idx_d   = '0;
              state_d = rss_pkg::StEmitRd;
            end
          end else if (fill_q == '0) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = in_rec;
            fill_d    = fill_p1;
            if (in_i.load_last) begin
              idx_d   = '0;
              state_d = rss_pkg::StEmitRd;
            end
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AddrW'(fill_q - 1'b1);
            idx_d     = fill_q;
            state_d   = rss_pkg::StCmp;
          end
        end
      end

      rss_pkg::StCmp: begin
        mem_we = 1'b1;
        if (key_le) begin
          // shift the held record one slot toward the tail
          mem_wdata = mem_rdata;
          idx_d     = idx_m1;
          if (idx_m1 == '0) begin
            state_d = rss_pkg::StPlace;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_m2[AddrW-1:0];
          end
        end else begin
          fill_d = fill_p1;
          if (last_q) begin
            idx_d   = '0;
            state_d = rss_pkg::StEmitRd;
          end else begin
            state_d = rss_pkg::StIdle;
          end
        end
      end

      rss_pkg::StPlace: begin
        mem_we = 1'b1;
        fill_d = fill_p1;
        if (last_q) begin
          idx_d   = '0;
          state_d = rss_pkg::StEmitRd;
        end else begin
          state_d = rss_pkg::StIdle;
        end
      end

      rss_pkg::StEmitRd: begin
        mem_re    = 1'b1;
        mem_raddr = idx_q[AddrW-1:0];
        state_d   = rss_pkg::StEmitLd;
      end

      rss_pkg::StEmitLd: begin
        if (!oval_q || out_o.ready) begin
          oload  = 1'b1;
          oval_d = 1'b1;
          if (olast_d) begin
            fill_d  = '0;
            ovf_d   = 1'b0;
            idx_d   = '0;
            state_d = rss_pkg::StIdle;
          end else begin
            idx_d   = idx_p1;
            state_d = rss_pkg::StEmitRd;
          end
        end
      end

      default: begin
        state_d = rss_pkg::StIdle;
      end
    endcase
  end

  assign out_o.valid          = oval_q;
  assign out_o.out_id         = orec_q.id;
  assign out_o.out_quantity   = orec_q.quantity;
  assign out_o.out_label      = orec_q.label;
  assign out_o.out_last       = olast_q;
  assign out_o.out_overflowed = oovf_q;

endmodule

### hw/rtl/rss_mem.sv
module rss_mem #(
  parameter int DEPTH = rss_pkg::DefaultDepth
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  rss_pkg::rec_t            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output rss_pkg::rec_t            rdata_o
);

  rss_pkg::rec_t mem_q [DEPTH];
  rss_pkg::rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/rss_keycmp.sv
module rss_keycmp (
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               le_o
);

  // signed key compare, true when a <= b
  assign le_o = (a_i <= b_i);

endmodule

### hw/rtl/rss_checker.sv
module rss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_id_i,
  input logic        out_last_i,
  input logic        out_ovf_i,
  input logic        pready_i
);

  logic busy_q;

  // set by a final transaction in, cleared once the final result shows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_valid_i && in_ready_i && in_last_i) begin
      busy_q <= 1'b1;
    end else if (out_valid_i && out_last_i) begin
      busy_q <= 1'b0;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_id_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !(out_valid_i && out_last_i) |-> !in_ready_i)
    else $error("input ready during a run");

  a_ovf_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i ##1 out_valid_i |-> $stable(out_ovf_i))
    else $error("overflow flag changed within a run");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("pready low");

endmodule

bind record_stack_sort_by_key rss_checker u_rss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.load_last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_id_i    (out_o.out_id),
  .out_last_i  (out_o.out_last),
  .out_ovf_i   (out_o.out_overflowed),
  .pready_i    (pready)
);

### test/rss_sort_checker.sv
module rss_sort_checker #(
  parameter int DEPTH = rss_pkg::DefaultDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rss_in_if                          in_mon,
  rss_out_if                         out_mon,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rss_pkg::PaddrW-1:0] paddr,
  input  logic [rss_pkg::PdataW-1:0] pwdata,
  input  logic [rss_pkg::PdataW-1:0] prdata,
  input  logic                       pready,
  output int                         fail_count_o,
  output int                         pending_o
);

  typedef struct packed {
    rss_pkg::rec_t rec;
    logic          last;
    logic          ovf;
  } emitted_t;

  rss_pkg::rec_t            sorted_recs [DEPTH];
  int unsigned              held_count;
  logic                     held_ovf;
  logic [rss_pkg::CapW-1:0] cap_reg;
  emitted_t                 due_q [$];

  function automatic int unsigned cap_limit(logic [rss_pkg::CapW-1:0] c);
    if (c == 0) return 1;
    if (c > DEPTH) return DEPTH;
    return 32'(c);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count_o++;
  endtask

  task automatic stack_push(input rss_pkg::rec_t r, input logic last);
    int unsigned pos;
    emitted_t    e;
    pos = 0;
    if (held_count >= cap_limit(cap_reg)) begin
      held_ovf = 1'b1;
    end else begin
      // newest record goes ahead of equal keys
      while (pos < held_count && $signed(sorted_recs[pos].quantity) > $signed(r.quantity))
        pos++;
      for (int unsigned i = held_count; i > pos; i--) sorted_recs[i] = sorted_recs[i-1];
      sorted_recs[pos] = r;
      held_count++;
    end
    if (last) begin
      for (int unsigned k = 0; k < held_count; k++) begin
        e.rec  = sorted_recs[k];
        e.last = (k + 1 == held_count);
        e.ovf  = held_ovf;
        due_q.push_back(e);
      end
      held_count = 0;
      held_ovf   = 1'b0;
    end
  endtask

  task automatic check_result();
    emitted_t want;
    if (due_q.size() == 0) begin
      report_mismatch("unexpected transaction", 64'(out_mon.out_id), 64'd0);
      return;
    end
    want = due_q.pop_front();
    if (out_mon.out_id !== want.rec.id)
      report_mismatch("out_id", 64'(out_mon.out_id), 64'(want.rec.id));
    if (out_mon.out_quantity !== want.rec.quantity)
      report_mismatch("out_quantity", 64'(out_mon.out_quantity), 64'(want.rec.quantity));
    if (out_mon.out_label !== want.rec.label)
      report_mismatch("out_label", out_mon.out_label, want.rec.label);
    if (out_mon.out_last !== want.last)
      report_mismatch("out_last", 64'(out_mon.out_last), 64'(want.last));
    if (out_mon.out_overflowed !== want.ovf)
      report_mismatch("out_overflowed", 64'(out_mon.out_overflowed), 64'(want.ovf));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count   = 0;
      held_ovf     = 1'b0;
      cap_reg      = rss_pkg::CapReset;
      due_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (psel && penable && pready && paddr[rss_pkg::PaddrW-1:2] == rss_pkg::RegCapIdx) begin
        if (pwrite) begin
          cap_reg = pwdata[rss_pkg::CapW-1:0];
        end else if (prdata !== rss_pkg::PdataW'(cap_reg)) begin
          report_mismatch("prdata", 64'(prdata), 64'(cap_reg));
        end
      end
      if (in_mon.valid && in_mon.ready)
        stack_push({in_mon.rec_id, in_mon.rec_quantity, in_mon.rec_label}, in_mon.load_last);
      pending_o = due_q.size();
    end
  end

endmodule

### test/tb_record_stack_sort_by_key.sv
module tb_record_stack_sort_by_key;

  localparam int   Depth        = rss_pkg::DefaultDepth;
  localparam int   CycleLimit   = 400000;
  localparam int   SettleCycles = 3 * Depth + 16;
  localparam int   HoldCycles   = 400;
  localparam int   RandomItems  = 460;
  localparam logic RegSpareIdx  = 1'b1;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [rss_pkg::PaddrW-1:0] paddr;
  logic [rss_pkg::PdataW-1:0] pwdata;
  logic [rss_pkg::PdataW-1:0] prdata;
  logic                       pready;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int items_sent  = 0;
  bit calm        = 1'b0;
  bit hold_req    = 1'b0;

  rss_in_if  in_ch ();
  rss_out_if out_ch ();

  record_stack_sort_by_key #(.DEPTH(Depth)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rss_sort_checker #(.DEPTH(Depth)) chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic offer_record(input logic [31:0] id, input logic [31:0] qty,
                              input logic [63:0] lbl, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(14, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.rec_id       <= id;
    in_ch.rec_quantity <= qty;
    in_ch.rec_label    <= lbl;
    in_ch.load_last    <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_load(input int n, input bit tie_heavy);
    logic [31:0] q;
    for (int k = 0; k < n; k++) begin
      q = tie_heavy ? 32'($urandom_range(6, 0)) - 32'd3 : $urandom;
      offer_record($urandom, q, {$urandom, $urandom}, k == n - 1);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic idx, input logic wr, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= rss_pkg::PaddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_capacity(input int c);
    drain();
    apb_access(rss_pkg::RegCapIdx, 1'b1, c);
    apb_access(rss_pkg::RegCapIdx, 1'b0, 32'd0);
  endtask

  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      gap = calm ? 0 : $urandom_range(14, 0);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  initial begin
    int phase;
    int size;
    int start_count;
    rst_ni             <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.rec_id       <= '0;
    in_ch.rec_quantity <= '0;
    in_ch.rec_label    <= '0;
    in_ch.load_last    <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset capacity, single-record load, key extremes and ties
    apb_access(rss_pkg::RegCapIdx, 1'b0, 32'd0);
    offer_record(32'h8000_0000, 32'h7FFF_FFFF, '1, 1'b1);
    offer_record(32'h7FFF_FFFF, 32'h8000_0000, 64'd0, 1'b0);
    offer_record(32'd0, 32'd0, {$urandom, $urandom}, 1'b0);
    offer_record(32'hFFFF_FFFF, 32'h7FFF_FFFF, '1, 1'b0);
    offer_record(32'd1, 32'hFFFF_FFFF, {$urandom, $urandom}, 1'b0);
    offer_record(32'd2, 32'd5, {$urandom, $urandom}, 1'b0);
    offer_record(32'd3, 32'd5, {$urandom, $urandom}, 1'b0);
    offer_record(32'd4, 32'd5, {$urandom, $urandom}, 1'b0);
    offer_record(32'd5, 32'h8000_0000, {$urandom, $urandom}, 1'b1);

    // zero capacity acts as one
    set_capacity(0);
    offer_record(32'd10, 32'd1, {$urandom, $urandom}, 1'b0);
    offer_record(32'd11, 32'd2, {$urandom, $urandom}, 1'b0);
    offer_record(32'd12, 32'd3, {$urandom, $urandom}, 1'b1);

    // only the last push dropped
    set_capacity(2);
    offer_record(32'd20, 32'd7, {$urandom, $urandom}, 1'b0);
    offer_record(32'd21, 32'd7, {$urandom, $urandom}, 1'b0);
    offer_record(32'd22, 32'd9, {$urandom, $urandom}, 1'b1);

    // capacity lowered below the fill mid-load
    set_capacity(64);
    for (int k = 0; k < 5; k++) offer_record($urandom, $urandom, {$urandom, $urandom}, 1'b0);
    set_capacity(3);
    offer_record($urandom, $urandom, {$urandom, $urandom}, 1'b0);
    offer_record($urandom, $urandom, {$urandom, $urandom}, 1'b1);

    // unused register index
    drain();
    apb_access(RegSpareIdx, 1'b1, 32'd5);
    apb_access(RegSpareIdx, 1'b0, 32'd0);
    apb_access(rss_pkg::RegCapIdx, 1'b0, 32'd0);

    start_count = items_sent;

    // output held off while input keeps coming
    set_capacity(64);
    hold_req = 1'b1;
    send_load(12, 1'b0);
    send_load(6, 1'b1);

    phase = 0;
    while (items_sent < start_count + RandomItems) begin
      case (phase % 6)
        0: set_capacity(64);
        1: set_capacity(1);
        2: set_capacity(127);
        3: set_capacity(65);
        4: set_capacity(0);
        default: set_capacity($urandom_range(64, 1));
      endcase
      calm = ($urandom_range(3, 0) == 0);
      repeat ($urandom_range(6, 3)) begin
        size = ($urandom_range(9, 0) == 0) ? $urandom_range(72, 30) : $urandom_range(8, 1);
        send_load(size, 1'($urandom_range(1, 0)));
      end
      phase++;
    end
    calm = 1'b0;
    drain();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/rss_pkg.sv
hw/rtl/rss_if.sv
hw/rtl/rss_mem.sv
hw/rtl/rss_keycmp.sv
hw/rtl/record_stack_sort_by_key.sv
hw/rtl/rss_checker.sv
test/rss_sort_checker.sv
test/tb_record_stack_sort_by_key.sv
